[design/hvb_pkg.sv]
// Shared types, constants and tables of the heading vote bearing estimator.
package hvb_pkg;

    // Angle format and CORDIC length
    localparam int ANGLE_FRAC_BITS = 12;
    localparam int CORDIC_STEPS    = 16;

    // Field widths
    localparam int HEAD_W  = 15;
    localparam int CHG_W   = 9;
    localparam int LIMIT_W = 8;
    localparam int SECT_W  = 3;

    // Vote bins
    localparam int NUM_BINS = 8;
    localparam int BIN_W    = 8;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd5;

    // Angles in Q30 radians
    localparam longint PI_Q30    = 64'sd3373259426;
    localparam int     ANG_SHIFT = 30 - ANGLE_FRAC_BITS;
    localparam longint PI_OUT    = (PI_Q30 + (longint'(1) << (ANG_SHIFT - 1))) >>> ANG_SHIFT;

    // Heading scaled to Q30 for the sector compare
    localparam int HQ_W = HEAD_W + ANG_SHIFT + 1;

    // Sector boundaries: odd multiples of pi/8, truncated toward zero
    localparam logic signed [HQ_W-1:0] SECTOR_BOUND [NUM_BINS] = '{
        HQ_W'(-((PI_Q30 * 7) / 8)),
        HQ_W'(-((PI_Q30 * 5) / 8)),
        HQ_W'(-((PI_Q30 * 3) / 8)),
        HQ_W'(-(PI_Q30 / 8)),
        HQ_W'(PI_Q30 / 8),
        HQ_W'((PI_Q30 * 3) / 8),
        HQ_W'((PI_Q30 * 5) / 8),
        HQ_W'((PI_Q30 * 7) / 8)
    };

    // Vector sum arithmetic
    localparam int DIAG_W     = 17;
    localparam logic signed [DIAG_W-1:0] DIAG_Q16 = 17'sd46341;
    localparam int UNIT_SHIFT = 16;
    localparam int VEC_SHIFT  = 8;
    localparam int A_W        = BIN_W + 1;
    localparam int C_W        = BIN_W + 2;
    localparam int PROD_W     = C_W + DIAG_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int CW         = SUM_W + VEC_SHIFT + 2;

    // CORDIC angle accumulator and table
    localparam int ZW        = 35;
    localparam int RND_W     = ZW - ANG_SHIFT;
    localparam int TABLE_LEN = 24;
    localparam int IDX_W     = $clog2(TABLE_LEN);
    localparam int STEP_W    = $clog2(CORDIC_STEPS);

    localparam logic signed [ZW-1:0]     PI_Z         = ZW'(PI_Q30);
    localparam logic signed [ZW-1:0]     RND_HALF     = ZW'(longint'(1) << (ANG_SHIFT - 1));
    localparam logic signed [RND_W-1:0]  PI_RND       = RND_W'(PI_OUT);
    localparam logic signed [HEAD_W-1:0] BEARING_MAX  = HEAD_W'(PI_OUT);

    localparam logic signed [ZW-1:0] ATAN_Q30 [TABLE_LEN] = '{
        35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159,
        35'sd67021687,  35'sd33543516,  35'sd16775851,  35'sd8388437,
        35'sd4194283,   35'sd2097149,   35'sd1048576,   35'sd524288,
        35'sd262144,    35'sd131072,    35'sd65536,     35'sd32768,
        35'sd16384,     35'sd8192,      35'sd4096,      35'sd2048,
        35'sd1024,      35'sd512,       35'sd256,       35'sd128
    };

    // Queue depth (power of two)
    localparam int Q_DEPTH = 2;
    localparam int QA_W    = $clog2(Q_DEPTH);

    // Classified input word
    typedef struct packed {
        logic [SECT_W-1:0] sector;
        logic              vote_up;
        logic              vote_down;
        logic              clear;
    } t_cls;

    // CORDIC request and response
    typedef struct packed {
        logic                 start;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } t_cor_req;

    typedef struct packed {
        logic                     done;
        logic signed [HEAD_W-1:0] angle;
    } t_cor_rsp;

endpackage

[design/hvb_front.sv]
// Front end: sorts the heading into a sector and decodes the vote direction.
module hvb_front (
    input  logic signed [hvb_pkg::HEAD_W-1:0] i_heading,
    input  logic signed [hvb_pkg::CHG_W-1:0]  i_strength_change,
    input  logic                              i_clear_votes,
    output hvb_pkg::t_cls                     o_cls
);

    logic signed [hvb_pkg::HQ_W-1:0] hq;
    logic [hvb_pkg::SECT_W:0]        cnt;

    // Count the boundaries at or below the heading
    always_comb begin
        hq  = hvb_pkg::HQ_W'(i_heading) <<< hvb_pkg::ANG_SHIFT;
        cnt = '0;
        for (int j = 0; j < hvb_pkg::NUM_BINS; j++) begin
            if (hq >= hvb_pkg::SECTOR_BOUND[j]) begin
                cnt = cnt + 1'b1;
            end
        end
    end

    // Wrap the count so that the band around +-pi lands in the last sector
    always_comb begin
        o_cls.sector    = hvb_pkg::SECT_W'(cnt + (hvb_pkg::SECT_W + 1)'(hvb_pkg::NUM_BINS - 1));
        o_cls.vote_up   = !i_strength_change[hvb_pkg::CHG_W-1] && (i_strength_change != '0);
        o_cls.vote_down = i_strength_change[hvb_pkg::CHG_W-1];
        o_cls.clear     = i_clear_votes;
    end

endmodule

[design/hvb_queue.sv]
// Short queue of classified words between the front and back ends.
module hvb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hvb_pkg::t_cls i_push_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output hvb_pkg::t_cls o_pop_data
);

    hvb_pkg::t_cls              r_mem [hvb_pkg::Q_DEPTH];
    logic [hvb_pkg::QA_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [hvb_pkg::QA_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [hvb_pkg::QA_W:0]     r_count, n_count;
    logic                       do_push, do_pop;

    always_comb begin
        o_full     = (r_count == (hvb_pkg::QA_W + 1)'(hvb_pkg::Q_DEPTH));
        o_valid    = (r_count != '0);
        o_pop_data = r_mem[r_rd_ptr];
        do_push    = i_push && !o_full;
        do_pop     = i_pop && o_valid;
        n_wr_ptr   = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr   = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count    = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

[design/hvb_cordic.sv]
// Iterative vectoring CORDIC that returns atan2(y, x) in Q3.12 radians.
module hvb_cordic (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hvb_pkg::t_cor_req i_req,
    output hvb_pkg::t_cor_rsp o_rsp
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_PREP = 2'd1;
    localparam logic [1:0] C_RUN  = 2'd2;
    localparam logic [1:0] C_FIN  = 2'd3;

    logic [1:0]                          r_state, n_state;
    logic signed [hvb_pkg::CW-1:0]       r_x, n_x;
    logic signed [hvb_pkg::CW-1:0]       r_y, n_y;
    logic signed [hvb_pkg::ZW-1:0]       r_z, n_z;
    logic [hvb_pkg::STEP_W-1:0]          r_step, n_step;
    logic                                r_zero, n_zero;
    logic                                r_done, n_done;
    logic signed [hvb_pkg::HEAD_W-1:0]   r_angle, n_angle;

    logic signed [hvb_pkg::CW-1:0]       dx, dy;
    logic signed [hvb_pkg::ZW-1:0]       ang_step;
    logic signed [hvb_pkg::RND_W-1:0]    rnd;
    logic signed [hvb_pkg::RND_W-1:0]    clamped;

    always_comb begin
        dx       = r_y >>> r_step;
        dy       = r_x >>> r_step;
        ang_step = hvb_pkg::ATAN_Q30[hvb_pkg::IDX_W'(r_step)];
        rnd      = hvb_pkg::RND_W'((r_z + hvb_pkg::RND_HALF) >>> hvb_pkg::ANG_SHIFT);
        clamped  = rnd;
        if (rnd > hvb_pkg::PI_RND) begin
            clamped = hvb_pkg::PI_RND;
        end else if (rnd < -hvb_pkg::PI_RND) begin
            clamped = -hvb_pkg::PI_RND;
        end
    end

    // Sequence: load, fold into the right half plane, rotate, round
    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_step  = r_step;
        n_zero  = r_zero;
        n_done  = 1'b0;
        n_angle = r_angle;
        case (r_state)
            C_IDLE: begin
                if (i_req.start) begin
                    n_x     = i_req.x;
                    n_y     = i_req.y;
                    n_state = C_PREP;
                end
            end
            C_PREP: begin
                n_zero = (r_x == '0) && (r_y == '0);
                n_step = '0;
                if (r_x < 0) begin
                    n_z = (r_y >= 0) ? hvb_pkg::PI_Z : -hvb_pkg::PI_Z;
                    n_x = -r_x;
                    n_y = -r_y;
                end else begin
                    n_z = '0;
                end
                n_state = C_RUN;
            end
            C_RUN: begin
                if (r_y >= 0) begin
                    n_x = r_x + dx;
                    n_y = r_y - dy;
                    n_z = r_z + ang_step;
                end else begin
                    n_x = r_x - dx;
                    n_y = r_y + dy;
                    n_z = r_z - ang_step;
                end
                n_step = r_step + 1'b1;
                if (r_step == hvb_pkg::STEP_W'(hvb_pkg::CORDIC_STEPS - 1)) begin
                    n_state = C_FIN;
                end
            end
            C_FIN: begin
                n_angle = r_zero ? '0 : hvb_pkg::HEAD_W'(clamped);
                n_done  = 1'b1;
                n_state = C_IDLE;
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
        r_step  <= n_step;
        r_zero  <= n_zero;
        r_angle <= n_angle;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.angle = r_angle;

endmodule

[design/hvb_back.sv]
// Back end: vote bins, decay, vector sum, CORDIC control and result register.
module hvb_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [hvb_pkg::LIMIT_W-1:0]        i_cfg_wdata,
    input  logic                               i_q_valid,
    input  hvb_pkg::t_cls                      i_q_data,
    output logic                               o_q_pop,
    output hvb_pkg::t_cor_req                  o_cor_req,
    input  hvb_pkg::t_cor_rsp                  i_cor_rsp,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [hvb_pkg::HEAD_W-1:0]  o_bearing,
    output logic                               o_bearing_valid,
    output logic [hvb_pkg::SECT_W-1:0]         o_sector
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_VOTE  = 3'd1;
    localparam logic [2:0] S_DECAY = 3'd2;
    localparam logic [2:0] S_MULT  = 3'd3;
    localparam logic [2:0] S_SUM   = 3'd4;
    localparam logic [2:0] S_ATAN  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]                           r_state, n_state;
    logic [hvb_pkg::LIMIT_W-1:0]          r_limit;
    hvb_pkg::t_cls                        r_cls, n_cls;
    logic [hvb_pkg::BIN_W-1:0]            r_bins [hvb_pkg::NUM_BINS];
    logic [hvb_pkg::BIN_W-1:0]            n_bins [hvb_pkg::NUM_BINS];
    logic signed [hvb_pkg::A_W-1:0]       r_a, n_a;
    logic signed [hvb_pkg::A_W-1:0]       r_d, n_d;
    logic signed [hvb_pkg::PROD_W-1:0]    r_pc, n_pc;
    logic signed [hvb_pkg::PROD_W-1:0]    r_pe, n_pe;
    logic                                 r_any, n_any;
    logic signed [hvb_pkg::HEAD_W-1:0]    r_bearing, n_bearing;
    logic                                 r_out_valid, n_out_valid;
    logic signed [hvb_pkg::HEAD_W-1:0]    r_out_bearing, n_out_bearing;
    logic                                 r_out_bvalid, n_out_bvalid;
    logic [hvb_pkg::SECT_W-1:0]           r_out_sector, n_out_sector;

    logic [hvb_pkg::SECT_W-1:0]           opp;
    logic                                 any_now;
    logic                                 exceed;
    logic signed [hvb_pkg::C_W-1:0]       c_sum, e_sum;
    logic signed [hvb_pkg::SUM_W-1:0]     x_sum, y_sum;
    logic                                 out_free;

    // Bin reductions over independent compares
    always_comb begin
        opp     = r_cls.sector + hvb_pkg::SECT_W'(hvb_pkg::NUM_BINS / 2);
        any_now = 1'b0;
        exceed  = 1'b0;
        for (int i = 0; i < hvb_pkg::NUM_BINS; i++) begin
            any_now = any_now | (r_bins[i] != '0);
            exceed  = exceed | (r_bins[i] > r_limit);
        end
        c_sum = $signed(hvb_pkg::C_W'(r_bins[2])) + $signed(hvb_pkg::C_W'(r_bins[4]))
              - $signed(hvb_pkg::C_W'(r_bins[0])) - $signed(hvb_pkg::C_W'(r_bins[6]));
        e_sum = $signed(hvb_pkg::C_W'(r_bins[4])) + $signed(hvb_pkg::C_W'(r_bins[6]))
              - $signed(hvb_pkg::C_W'(r_bins[0])) - $signed(hvb_pkg::C_W'(r_bins[2]));
        x_sum = (hvb_pkg::SUM_W'(r_a) <<< hvb_pkg::UNIT_SHIFT) + hvb_pkg::SUM_W'(r_pc);
        y_sum = (hvb_pkg::SUM_W'(r_d) <<< hvb_pkg::UNIT_SHIFT) + hvb_pkg::SUM_W'(r_pe);
        out_free = !r_out_valid || !i_out_stall;
    end

    // CORDIC request
    always_comb begin
        o_cor_req.start = (r_state == S_SUM) && r_any;
        o_cor_req.x     = hvb_pkg::CW'(x_sum) <<< hvb_pkg::VEC_SHIFT;
        o_cor_req.y     = hvb_pkg::CW'(y_sum) <<< hvb_pkg::VEC_SHIFT;
    end

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_cls         = r_cls;
        n_bins        = r_bins;
        n_a           = r_a;
        n_d           = r_d;
        n_pc          = r_pc;
        n_pe          = r_pe;
        n_any         = r_any;
        n_bearing     = r_bearing;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_bearing = r_out_bearing;
        n_out_bvalid  = r_out_bvalid;
        n_out_sector  = r_out_sector;
        o_q_pop       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cls   = i_q_data;
                    n_state = S_VOTE;
                end
            end
            S_VOTE: begin
                // apply the vote or empty the bins
                for (int i = 0; i < hvb_pkg::NUM_BINS; i++) begin
                    if (r_cls.clear) begin
                        n_bins[i] = '0;
                    end else if (hvb_pkg::SECT_W'(i) == r_cls.sector) begin
                        if (r_cls.vote_up && (r_bins[i] != '1)) begin
                            n_bins[i] = r_bins[i] + 1'b1;
                        end else if (r_cls.vote_down && (r_bins[i] != '0)) begin
                            n_bins[i] = r_bins[i] - 1'b1;
                        end
                    end else if (hvb_pkg::SECT_W'(i) == opp) begin
                        if (r_cls.vote_up && (r_bins[i] != '0)) begin
                            n_bins[i] = r_bins[i] - 1'b1;
                        end else if (r_cls.vote_down && (r_bins[i] != '1)) begin
                            n_bins[i] = r_bins[i] + 1'b1;
                        end
                    end
                end
                n_state = S_DECAY;
            end
            S_DECAY: begin
                // decay every nonzero bin once any bin passes the limit
                if (exceed) begin
                    for (int i = 0; i < hvb_pkg::NUM_BINS; i++) begin
                        if (r_bins[i] != '0) begin
                            n_bins[i] = r_bins[i] - 1'b1;
                        end
                    end
                end
                n_state = S_MULT;
            end
            S_MULT: begin
                n_a     = $signed(hvb_pkg::A_W'(r_bins[3])) - $signed(hvb_pkg::A_W'(r_bins[7]));
                n_d     = $signed(hvb_pkg::A_W'(r_bins[5])) - $signed(hvb_pkg::A_W'(r_bins[1]));
                n_pc    = hvb_pkg::PROD_W'(c_sum) * hvb_pkg::PROD_W'(hvb_pkg::DIAG_Q16);
                n_pe    = hvb_pkg::PROD_W'(e_sum) * hvb_pkg::PROD_W'(hvb_pkg::DIAG_Q16);
                n_any   = any_now;
                n_state = S_SUM;
            end
            S_SUM: begin
                if (r_any) begin
                    n_state = S_ATAN;
                end else begin
                    n_bearing = '0;
                    n_state   = S_OUT;
                end
            end
            S_ATAN: begin
                if (i_cor_rsp.done) begin
                    n_bearing = i_cor_rsp.angle;
                    n_state   = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_bearing = r_bearing;
                    n_out_bvalid  = r_any;
                    n_out_sector  = r_cls.sector;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, bins and limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= hvb_pkg::LIMIT_RESET;
            r_out_valid <= 1'b0;
            for (int i = 0; i < hvb_pkg::NUM_BINS; i++) begin
                r_bins[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_bins      <= n_bins;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_cls         <= n_cls;
        r_a           <= n_a;
        r_d           <= n_d;
        r_pc          <= n_pc;
        r_pe          <= n_pe;
        r_any         <= n_any;
        r_bearing     <= n_bearing;
        r_out_bearing <= n_out_bearing;
        r_out_bvalid  <= n_out_bvalid;
        r_out_sector  <= n_out_sector;
    end

    assign o_out_valid     = r_out_valid;
    assign o_bearing       = r_out_bearing;
    assign o_bearing_valid = r_out_bvalid;
    assign o_sector        = r_out_sector;

    // CORDIC answers only while the sequencer waits for it
    a_cor_done_in_atan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cor_rsp.done |-> (r_state == S_ATAN))
        else $error("CORDIC result arrived outside the wait state");

    // A clear leaves every bin empty
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECAY) && r_cls.clear |-> !any_now)
        else $error("bins not empty after clear");

    // Empty bins report a zero bearing
    a_zero_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_bvalid |-> (r_out_bearing == '0))
        else $error("nonzero bearing without votes");

    // Bearing stays within plus or minus pi
    a_bearing_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_bearing <= hvb_pkg::BEARING_MAX)
                     && (r_out_bearing >= -hvb_pkg::BEARING_MAX))
        else $error("bearing out of range");

endmodule

[design/heading_vote_bearing_estimator_core.sv]
// Top level of the heading vote bearing estimator.
// Each input word is classified into one of eight heading sectors and queued; the back
// end then updates the vote bins, applies the decay rule against vote_limit, forms the
// vote-weighted vector sum and runs a 16-step iterative CORDIC for the bearing, one
// micro-rotation per cycle; the two-word queue lets the input side accept while
// the back end is busy, and the result register holds a finished word while the next is
// computed. vote_limit resets to 5 and should be written only while the block is idle.
module heading_vote_bearing_estimator_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [hvb_pkg::LIMIT_W-1:0]        i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [hvb_pkg::HEAD_W-1:0]  i_heading,
    input  logic signed [hvb_pkg::CHG_W-1:0]   i_strength_change,
    input  logic                               i_clear_votes,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [hvb_pkg::HEAD_W-1:0]  o_bearing,
    output logic                               o_bearing_valid,
    output logic [hvb_pkg::SECT_W-1:0]         o_sector
);

    hvb_pkg::t_cls     front_cls;
    hvb_pkg::t_cls     q_data;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    hvb_pkg::t_cor_req cor_req;
    hvb_pkg::t_cor_rsp cor_rsp;

    // Classify the input word
    hvb_front u_front (
        .i_heading         (i_heading),
        .i_strength_change (i_strength_change),
        .i_clear_votes     (i_clear_votes),
        .o_cls             (front_cls)
    );

    // Hold classified words for the back end
    hvb_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_in_valid),
        .i_push_data (front_cls),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_pop_data  (q_data)
    );

    assign o_in_stall = q_full;

    // atan2 unit used by the back end
    hvb_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cor_req),
        .o_rsp   (cor_rsp)
    );

    // Vote bins and result
    hvb_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_q_valid       (q_valid),
        .i_q_data        (q_data),
        .o_q_pop         (q_pop),
        .o_cor_req       (cor_req),
        .i_cor_rsp       (cor_rsp),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_bearing       (o_bearing),
        .o_bearing_valid (o_bearing_valid),
        .o_sector        (o_sector)
    );

endmodule
